// ===== sv/tdpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpc_pkg
// Types, request codes and helpers shared by the timed dose pump controller.
// ----------------------------------------------------------------------------
package tdpc_pkg;

	localparam logic [2:0] REQ_TICK       = 3'd0;
	localparam logic [2:0] REQ_SET_ON     = 3'd1;
	localparam logic [2:0] REQ_SET_SPEED  = 3'd2;
	localparam logic [2:0] REQ_DISPENSE   = 3'd3;
	localparam logic [2:0] REQ_CAL_START  = 3'd4;
	localparam logic [2:0] REQ_CAL_RESULT = 3'd5;

	localparam logic [7:0]  LEVEL_STOP  = 8'd255;
	localparam logic [31:0] CAL_DEFAULT = 32'd70000;
	localparam logic [15:0] CAL_AMOUNT  = 16'd100;
	localparam logic [6:0]  PCT_MAX     = 7'd100;
	// ceil(2^22 / 100), exact floor for products up to 100 * 255
	localparam logic [15:0] RECIP_100   = 16'd41944;

	typedef struct packed {
		logic        running;
		logic [7:0]  speed_code;
		logic [31:0] ms_per_ml;
		logic [31:0] dose_start;
		logic [31:0] dose_end;
		logic [15:0] dose_target;
	} tdpc_entry_t;

	localparam tdpc_entry_t ENTRY_RESET = '{
		running:     1'b0,
		speed_code:  8'd0,
		ms_per_ml:   CAL_DEFAULT,
		dose_start:  32'd0,
		dose_end:    32'd0,
		dose_target: 16'd0
	};

	// value * 10, modulo 2^32
	function automatic logic [31:0] times_ten(input logic [31:0] value);
		return (value << 3) + (value << 1);
	endfunction

	// 255 - clamp(pct, 0, 100) * 255 / 100
	function automatic logic [7:0] speed_code_f(input logic signed [15:0] pct);
		logic [6:0]  c;
		logic [14:0] prod;
		logic [30:0] scaled;
		if (pct[15]) begin
			c = 7'd0;
		end else if (pct > 16'sd100) begin
			c = PCT_MAX;
		end else begin
			c = pct[6:0];
		end
		prod   = {c, 8'd0} - 15'(c);
		scaled = 31'(prod) * 31'(RECIP_100);
		return LEVEL_STOP - scaled[29:22];
	endfunction

endpackage
`default_nettype wire

// ===== sv/tdpc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpc_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tdpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/timed_dose_pump_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_dose_pump_controller
// Per-pump on flag, speed, calibration and timed dispense, state held in RAM.
//
// An item is taken on a clock edge with start high and busy low: req_type,
// pump_index, on_flag, speed_pct, amount_ml10 and now_ms. The pump entry is
// read from the state RAM, updated and written back. Exactly one result per
// item: done is high for one cycle with pump_number, pwm_level, pump_running
// and cal_ms_per_ml; the receiver must take it then.
// Steps: read (S_RD), update (S_CALC), the 32-step serial divider (S_DIV)
// when a tick or calibration result needs it, write-back (S_WB); a pump out of
// range skips S_CALC and S_DIV. busy falls in the result cycle, so the next
// item may be taken at its closing edge; no item is taken while one is in flight.
// Reset clears the control state and the per-entry valid bits; an entry not
// yet written reads as its reset value (off, code 0, 70000 ms/ml, no dose).
// ----------------------------------------------------------------------------
module timed_dose_pump_controller #(
	parameter int PUMP_COUNT = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         req_type,
	input  wire logic               pump_index,
	input  wire logic               on_flag,
	input  wire logic signed [15:0] speed_pct,
	input  wire logic [15:0]        amount_ml10,
	input  wire logic [31:0]        now_ms,
	output logic                    done,
	output logic                    pump_number,
	output logic [7:0]              pwm_level,
	output logic                    pump_running,
	output logic [31:0]             cal_ms_per_ml
);

	import tdpc_pkg::*;

	localparam int AW    = (PUMP_COUNT > 1) ? $clog2(PUMP_COUNT) : 1;
	localparam int EW    = $bits(tdpc_entry_t);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_CALC = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;

	logic [2:0]            state_q;
	logic [PUMP_COUNT-1:0] valid_q;
	logic                  accept;

	logic [2:0]            req_q;
	logic                  pump_q;
	logic [AW-1:0]         addr_q;
	logic                  in_range_q;
	logic                  on_q;
	logic signed [15:0]    speed_q;
	logic [15:0]           amount_q;
	logic [31:0]           now_q;

	tdpc_entry_t           rd_entry;
	tdpc_entry_t           ent_q;
	tdpc_entry_t           nxt;
	logic [EW-1:0]         rd_data;

	logic                  tick_go;
	logic                  cal_go;
	logic                  need_div;

	logic [31:0]           dvd_q;
	logic [31:0]           dvs_q;
	logic [31:0]           rem_q;
	logic [31:0]           quo_q;
	logic [4:0]            cnt_q;
	logic [32:0]           trial;

	logic                  done_q;
	logic                  pump_out_q;
	logic [7:0]            level_q;
	logic                  run_out_q;
	logic [31:0]           cal_out_q;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	tdpc_ram #(
		.WIDTH (EW),
		.DEPTH (PUMP_COUNT)
	) u_state_ram (
		.clk   (clk),
		.we    (state_q == S_WB && in_range_q),
		.waddr (addr_q),
		.wdata (nxt),
		.re    (accept),
		.raddr (AW'(pump_index)),
		.rdata (rd_data)
	);

	assign rd_entry = valid_q[addr_q] ? tdpc_entry_t'(rd_data) : ENTRY_RESET;

	assign tick_go = ent_q.running && (ent_q.dose_start != 32'd0) &&
			(ent_q.dose_target != 16'd0) && (ent_q.ms_per_ml != 32'd0);
	assign cal_go  = (ent_q.dose_start != 32'd0) && (ent_q.dose_end != 32'd0) &&
			(ent_q.dose_end > ent_q.dose_start) && (amount_q != 16'd0);
	assign need_div = (req_q == REQ_TICK && tick_go) ||
			(req_q == REQ_CAL_RESULT && cal_go);

	assign trial = {rem_q, dvd_q[31]} - {1'b0, dvs_q};

	always_comb begin
		nxt = ent_q;
		case (req_q)
			REQ_TICK: begin
				if (tick_go && (quo_q[31] || quo_q >= 32'(ent_q.dose_target))) begin
					nxt.running  = 1'b0;
					nxt.dose_end = now_q;
				end
				if (!nxt.running) begin
					nxt.dose_target = 16'd0;
				end
			end
			REQ_SET_ON: begin
				nxt.running     = on_q;
				nxt.dose_start  = 32'd0;
				nxt.dose_target = 16'd0;
			end
			REQ_SET_SPEED: begin
				nxt.speed_code = speed_code_f(speed_q);
			end
			REQ_DISPENSE, REQ_CAL_START: begin
				nxt.dose_start  = now_q;
				nxt.dose_target = (req_q == REQ_DISPENSE) ? amount_q : CAL_AMOUNT;
				if (nxt.dose_target != 16'd0) begin
					nxt.running = 1'b1;
				end
			end
			REQ_CAL_RESULT: begin
				if (cal_go) begin
					nxt.ms_per_ml = quo_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= in_range_q ? S_CALC : S_WB;
				end
				S_CALC: begin
					state_q <= need_div ? S_DIV : S_WB;
				end
				S_DIV: begin
					if (cnt_q == 5'd0) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (in_range_q) begin
						valid_q[addr_q] <= 1'b1;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= req_type;
			pump_q     <= pump_index;
			addr_q     <= AW'(pump_index);
			in_range_q <= (32'(pump_index) < 32'(PUMP_COUNT));
			on_q       <= on_flag;
			speed_q    <= speed_pct;
			amount_q   <= amount_ml10;
			now_q      <= now_ms;
		end
		if (state_q == S_RD) begin
			ent_q <= rd_entry;
		end
		if (state_q == S_CALC) begin
			rem_q <= 32'd0;
			quo_q <= 32'd0;
			cnt_q <= 5'd31;
			if (req_q == REQ_TICK) begin
				dvd_q <= times_ten(now_q - ent_q.dose_start);
				dvs_q <= ent_q.ms_per_ml;
			end else begin
				dvd_q <= times_ten(ent_q.dose_end - ent_q.dose_start);
				dvs_q <= 32'(amount_q);
			end
		end
		if (state_q == S_DIV) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			cnt_q <= cnt_q - 5'd1;
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], dvd_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (state_q == S_WB) begin
			pump_out_q <= pump_q;
			if (in_range_q) begin
				level_q   <= nxt.running ? nxt.speed_code : LEVEL_STOP;
				run_out_q <= nxt.running;
				cal_out_q <= nxt.ms_per_ml;
			end else begin
				level_q   <= LEVEL_STOP;
				run_out_q <= 1'b0;
				cal_out_q <= 32'd0;
			end
		end
	end

	assign done          = done_q;
	assign pump_number   = pump_out_q;
	assign pwm_level     = level_q;
	assign pump_running  = run_out_q;
	assign cal_ms_per_ml = cal_out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(state_q == S_WB))
		else $error("result strobe outside write-back");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> dvs_q != 32'd0)
		else $error("divider running with zero divisor");

	a_level_run: assert property (@(posedge clk) disable iff (!arst_n)
		done && !pump_running |-> pwm_level == LEVEL_STOP)
		else $error("stopped pump reports a drive level");

endmodule
`default_nettype wire
